// ===== rtl/scd_pkg.sv =====
// Shared types and constants for the 12-bit sample code decoder.
`timescale 1ns / 1ps

package scd_pkg;

   // Q20 coefficients of the recursive filter
   localparam int unsigned COEF_WIDTH     = 21;
   localparam int unsigned COEF_FRAC_BITS = 20;
   localparam logic [COEF_WIDTH-1:0] COEF_FEEDBACK = 21'd647719;
   localparam logic [COEF_WIDTH-1:0] COEF_CUR_MIX  = 21'd374536;
   localparam logic [COEF_WIDTH-1:0] COEF_PREV_MIX = 21'd25693;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned PROD_WIDTH = WORD_WIDTH + COEF_WIDTH;

   localparam int unsigned CODE_WIDTH = 12;
   localparam int unsigned PCM_WIDTH  = 16;

   // Output clipping and scaling constants
   localparam logic signed [WORD_WIDTH-1:0] CLIP_HI_LIMIT = 32'sd32767;
   localparam logic signed [WORD_WIDTH-1:0] CLIP_LO_LIMIT = -32'sd32767;
   localparam logic signed [PCM_WIDTH-1:0]  PCM_POS_SAT   = 16'sd32766;
   localparam logic signed [PCM_WIDTH-1:0]  PCM_NEG_SAT   = -16'sd32766;
   localparam int unsigned SCALE_SHIFT = 7;   // times 128
   localparam int unsigned DIV_SHIFT   = 15;  // divisor is 2^15 - 1
   localparam logic [DIV_SHIFT:0] DIVISOR = 16'd32767;
   localparam int unsigned MAG_WIDTH   = 30;  // |mix| * 128 in the unclipped range

   typedef enum logic [1:0] {
      COEF_SEL_FEEDBACK,
      COEF_SEL_CUR_MIX,
      COEF_SEL_PREV_MIX
   } coef_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_FB,
      ST_MUL_PREV,
      ST_MUL_CUR,
      ST_MIX,
      ST_EXPAND,
      ST_CLIP,
      ST_DIVIDE
   } state_type;

endpackage

// ===== rtl/scd_mul.sv =====
// Shared registered multiplier: signed word times a selected Q20 coefficient.
`timescale 1ns / 1ps

module scd_mul
   import scd_pkg::*;
(
   input  logic                          clock,
   input  logic                          mul_en,
   input  logic        [WORD_WIDTH-1:0]  operand,
   input  coef_sel_type                  coef_sel,
   output logic        [WORD_WIDTH-1:0]  scaled     // floor(operand * coef / 2^20), wrapped
);

   logic        [COEF_WIDTH-1:0] coef;
   logic signed [WORD_WIDTH-1:0] operand_s;
   logic signed [COEF_WIDTH:0]   coef_s;
   logic signed [PROD_WIDTH:0]   prod_in;
   logic signed [PROD_WIDTH:0]   prod_ff;

   always_comb begin
      unique case (coef_sel)
         COEF_SEL_FEEDBACK: coef = COEF_FEEDBACK;
         COEF_SEL_CUR_MIX:  coef = COEF_CUR_MIX;
         COEF_SEL_PREV_MIX: coef = COEF_PREV_MIX;
         default:           coef = COEF_FEEDBACK;
      endcase
   end

   assign operand_s = signed'(operand);
   assign coef_s    = signed'({1'b0, coef});
   assign prod_in   = operand_s * coef_s;

   // Hold the product between uses
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign scaled = prod_ff[COEF_FRAC_BITS +: WORD_WIDTH];

endmodule

// ===== rtl/sampler_12bit_code_decoder_unit.sv =====
// Top level of the 12-bit sample code decoder: sequencer, history and output clip.
//
//  channel  | ports             | tdata / tuser contents
//  ---------+-------------------+--------------------------------------------
//  request  | req_tvalid/tready | tdata[11:0] sample_code, tuser restart_history
//  response | rsp_tvalid/tready | tdata[15:0] pcm_sample (signed)
//
// A request occupies the block until its result is loaded. The result is loaded
// after three passes through the one shared multiplier (feedback, previous-mix
// and current-mix coefficients), then mix, expand, clip and a constant divide.
// The next request is taken in the cycle after the load. The multiplier is the
// only arithmetic unit reused.
// Reset clears the history, the sequencer and the response valid flag.
// A result not yet taken holds the sequencer in its last step; the next
// request is accepted as soon as the result has moved to the output register.
`timescale 1ns / 1ps

module sampler_12bit_code_decoder_unit
   import scd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] sample_code, [15:12] zero
   input  logic        req_tuser,   // [0] restart_history

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] pcm_sample
);

   state_type state_ff, state_in;

   logic [WORD_WIDTH-1:0] history_ff;
   logic [WORD_WIDTH-1:0] old_ff;
   logic [CODE_WIDTH-1:0] code_ff;
   logic [WORD_WIDTH-1:0] acc_ff;
   logic [WORD_WIDTH-1:0] mixed_ff;
   logic                  sat_hi_ff, sat_lo_ff, neg_ff;
   logic [MAG_WIDTH-1:0]  mag_ff;
   logic                  rsp_valid_ff;
   logic [PCM_WIDTH-1:0]  rsp_data_ff;

   // Sequencer outputs
   logic                  req_accept;
   logic                  rsp_load;
   logic                  mul_en;
   logic [WORD_WIDTH-1:0] mul_operand;
   coef_sel_type          coef_sel;
   logic [WORD_WIDTH-1:0] mul_scaled;

   // Datapath
   logic [WORD_WIDTH-1:0]        contrib;
   logic [WORD_WIDTH-1:0]        new_hist;
   logic [WORD_WIDTH-1:0]        expand_e;
   logic [WORD_WIDTH-1:0]        expanded;
   logic signed [WORD_WIDTH-1:0] coarse;
   logic [WORD_WIDTH-1:0]        mag_full;
   logic [DIV_SHIFT-1:0]         q_est;
   logic [DIV_SHIFT:0]           remainder;
   logic [DIV_SHIFT:0]           quotient;
   logic [PCM_WIDTH-1:0]         pcm_value;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_MUL_FB;
         ST_MUL_FB:   state_in = ST_MUL_PREV;
         ST_MUL_PREV: state_in = ST_MUL_CUR;
         ST_MUL_CUR:  state_in = ST_MIX;
         ST_MIX:      state_in = ST_EXPAND;
         ST_EXPAND:   state_in = ST_CLIP;
         ST_CLIP:     state_in = ST_DIVIDE;
         ST_DIVIDE:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: multiplier schedule and result load
   always_comb begin
      mul_en      = 1'b0;
      mul_operand = old_ff;
      coef_sel    = COEF_SEL_FEEDBACK;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_MUL_FB: begin
            mul_en   = 1'b1;
            coef_sel = COEF_SEL_FEEDBACK;
         end
         ST_MUL_PREV: begin
            mul_en   = 1'b1;
            coef_sel = COEF_SEL_PREV_MIX;
         end
         ST_MUL_CUR: begin
            mul_en      = 1'b1;
            mul_operand = history_ff;
            coef_sel    = COEF_SEL_CUR_MIX;
         end
         ST_DIVIDE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   scd_mul u_mul (
      .clock    (clock),
      .mul_en   (mul_en),
      .operand  (mul_operand),
      .coef_sel (coef_sel),
      .scaled   (mul_scaled)
   );

   // Sign-extended code in bits 23:12 over the low half of the old history, floor-shifted by 8
   assign contrib  = {{8{code_ff[CODE_WIDTH-1]}}, code_ff, 4'b0000, old_ff[15:8]};
   assign new_hist = contrib + mul_scaled;

   // Expand the mix by 1 + 1/8 + 1/16 with floor shifts
   assign expand_e = {{3{mixed_ff[WORD_WIDTH-1]}}, mixed_ff[WORD_WIDTH-1:3]};
   assign expanded = mixed_ff + expand_e + {expand_e[WORD_WIDTH-1], expand_e[WORD_WIDTH-1:1]};

   // Clip test on the coarse level, magnitude for the scaled path
   assign coarse   = signed'({{8{mixed_ff[WORD_WIDTH-1]}}, mixed_ff[WORD_WIDTH-1:8]});
   assign mag_full = mixed_ff[WORD_WIDTH-1] ? (~mixed_ff + 32'd1) : mixed_ff;

   // Divide by 2^15 - 1: estimate by shift, fix up by one compare
   assign q_est     = mag_ff[MAG_WIDTH-1 -: DIV_SHIFT];
   assign remainder = {1'b0, mag_ff[DIV_SHIFT-1:0]} + {1'b0, q_est};
   assign quotient  = (remainder >= DIVISOR) ? ({1'b0, q_est} + 16'd1) : {1'b0, q_est};

   always_comb begin
      priority if (sat_hi_ff) begin
         pcm_value = PCM_POS_SAT;
      end else if (sat_lo_ff) begin
         pcm_value = PCM_NEG_SAT;
      end else if (neg_ff) begin
         pcm_value = ~quotient + 16'd1;
      end else begin
         pcm_value = quotient;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         history_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_MUL_PREV) begin
            history_ff <= new_hist;
         end else if (req_accept && req_tuser) begin
            history_ff <= '0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         code_ff <= req_tdata[CODE_WIDTH-1:0];
         old_ff  <= req_tuser ? '0 : history_ff;
      end
      if (state_ff == ST_MUL_CUR) begin
         acc_ff <= mul_scaled;   // previous-mix term
      end
      if (state_ff == ST_MIX) begin
         mixed_ff <= mul_scaled + acc_ff;
      end else if (state_ff == ST_EXPAND) begin
         mixed_ff <= expanded;
      end
      if (state_ff == ST_CLIP) begin
         sat_hi_ff <= (coarse >= CLIP_HI_LIMIT);
         sat_lo_ff <= (coarse <= CLIP_LO_LIMIT);
         neg_ff    <= mixed_ff[WORD_WIDTH-1];
         mag_ff    <= {mag_full[MAG_WIDTH-SCALE_SHIFT-1:0], {SCALE_SHIFT{1'b0}}};
      end
      if (rsp_load) begin
         rsp_data_ff <= pcm_value;
      end
   end

endmodule
